### hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted schedule table package
// Shared constants, codes, entry and channel types, and the sort key.
// ----------------------------------------------------------------------------
package sst_pkg;

   // Table depth and the widths of the count, slot index and key.
   localparam int MAX_ENTRIES = 32;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int SLOT_W      = 5;
   localparam int CMP_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int COUNT_OUT_W = 6;
   localparam int KEY_W       = 14;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_REMOVE  = 2'd1;
   localparam logic [1:0] MODE_REPLACE = 2'd2;
   localparam logic [1:0] MODE_READ    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Per-cycle action of the cell row.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic [2:0] from_day;
      logic [4:0] from_hour;
      logic [5:0] start_minute;
      logic [5:0] stop_minute;
      logic [4:0] stop_hour;
      logic [2:0] stop_day;
      logic [1:0] preset;
   } entry_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [SLOT_W-1:0] slot_index;
      logic [5:0]        start_minute;
      logic [4:0]        from_hour;
      logic [2:0]        from_day;
      logic [5:0]        stop_minute;
      logic [4:0]        stop_hour;
      logic [2:0]        stop_day;
      logic [1:0]        preset;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [5:0]             rd_start_minute;
      logic [4:0]             rd_from_hour;
      logic [2:0]             rd_from_day;
      logic [5:0]             rd_stop_minute;
      logic [4:0]             rd_stop_hour;
      logic [2:0]             rd_stop_day;
      logic [1:0]             rd_preset;
   } rsp_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic [1:0] op;
      logic       replace;
      entry_type  entry;
   } cell_ctl_type;

   // Position flags of one cell relative to the count and the slot index.
   typedef struct packed {
      logic valid;
      logic tail;
      logic after_idx;
      logic sel;
   } cell_pos_type;

   function automatic key_type entry_key(input entry_type e);
      entry_key = {e.from_day, e.from_hour, e.start_minute};
   endfunction

endpackage

### hw/rtl/sst_ifs.sv
// ----------------------------------------------------------------------------
// Sorted schedule table channels
// Valid/ready request and response channels with typed payloads.
// ----------------------------------------------------------------------------
interface sst_req_if;
   import sst_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// Sorted schedule table cell
// Holds one entry and shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sst_cell (
   input  logic                 clock,
   input  sst_pkg::cell_ctl_type ctl,
   input  sst_pkg::cell_pos_type pos,
   input  sst_pkg::entry_type    left_entry,
   input  logic                  left_gt,
   input  sst_pkg::entry_type    right_entry,
   output logic                  gt,
   output sst_pkg::entry_type    entry,
   output sst_pkg::entry_type    rd_part
);
   import sst_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   key_type   own_key;
   key_type   new_key;

   always_comb begin
      own_key = entry_key(entry_ff);
      new_key = entry_key(ctl.entry);
      // Sits after the new entry. On the second half of a replace, entries
      // that came after the old slot also move past equal keys.
      gt = pos.valid && ((own_key > new_key) ||
                         (ctl.replace && pos.after_idx && (own_key == new_key)));
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt || pos.tail) begin
               entry_in = ctl.entry;
            end
         end
         CELL_REMOVE: begin
            if (pos.after_idx) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      rd_part = pos.sel ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/sorted_schedule_table.sv
// ----------------------------------------------------------------------------
// Sorted schedule table
// Bounded table of weekly schedule entries kept sorted by start time.
// ----------------------------------------------------------------------------
// The table holds up to MAX_ENTRIES schedule entries in a row of cells,
// always ordered by start day, hour and minute, with equal start times kept
// in the order they arrived. Each request inserts an entry, removes, replaces
// or reads the entry at slot_index, and produces exactly one response that
// carries a status, the entry count after the operation, and the entry's
// fields on a good read (zero otherwise). Insert, remove and read pass from
// the execute state to the done state, which loads the response register;
// replace passes an insert state between them, because the row first
// closes the gap at the old slot and then opens one at the new sorted
// place. A response that is still waiting in the output register holds the
// next result back in the done state while it stays there. Every cell
// compares its key with the broadcast entry and moves one step toward its
// neighbor together with all others, so an operation takes no longer in a
// deeper table. A new request is taken once the previous one has finished
// in the row, even while its response is still waiting in the output
// register.
module sorted_schedule_table (
   input logic      clock,
   input logic      reset,
   sst_req_if.sink   req_ch,
   sst_rsp_if.source rsp_ch
);
   import sst_pkg::*;

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_INSERT = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          op_ff, op_in;
   logic [1:0]       status_ff, status_in;
   entry_type        rd_ff, rd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctl_type     ctl;
   entry_type        new_entry;
   entry_type        rd_bus;
   logic             full;
   logic             out_of_range;
   logic             rsp_free;

   cell_pos_type     pos   [MAX_ENTRIES];
   entry_type        cells [MAX_ENTRIES];
   entry_type        parts [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] gt;

   // The request fields in entry form, as they are broadcast to the row.
   always_comb begin
      new_entry.from_day     = op_ff.from_day;
      new_entry.from_hour    = op_ff.from_hour;
      new_entry.start_minute = op_ff.start_minute;
      new_entry.stop_minute  = op_ff.stop_minute;
      new_entry.stop_hour    = op_ff.stop_hour;
      new_entry.stop_day     = op_ff.stop_day;
      new_entry.preset       = op_ff.preset;
   end

   assign full         = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign out_of_range = (CMP_W'(op_ff.slot_index) >= CMP_W'(count_ff));
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Row control. An insert opens a gap at the first entry whose key is
   // greater than the new one; a remove pulls the entries above the slot
   // down by one. A replace is a remove followed by an insert in which the
   // entries that came after the old slot also yield to equal keys.
   always_comb begin
      ctl.op      = CELL_HOLD;
      ctl.replace = 1'b0;
      ctl.entry   = new_entry;
      if (state_ff == S_EXEC) begin
         if (op_ff.mode == MODE_INSERT) begin
            if (!full) begin
               ctl.op = CELL_INSERT;
            end
         end else if (!out_of_range &&
                      ((op_ff.mode == MODE_REMOVE) || (op_ff.mode == MODE_REPLACE))) begin
            ctl.op = CELL_REMOVE;
         end
      end else if (state_ff == S_INSERT) begin
         ctl.op      = CELL_INSERT;
         ctl.replace = 1'b1;
      end
   end

   // The chain of cells. Each cell sees its left and right neighbor and the
   // greater-than flag of its left neighbor.
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      always_comb begin
         pos[g].valid     = (CNT_W'(g) < count_ff);
         pos[g].tail      = (CNT_W'(g) == count_ff);
         pos[g].after_idx = (CMP_W'(g) >= CMP_W'(op_ff.slot_index));
         pos[g].sel       = (CMP_W'(g) == CMP_W'(op_ff.slot_index));
      end

      if (g == 0) begin : g_first
         if (MAX_ENTRIES > 1) begin : g_more
            sst_cell u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .pos         (pos[g]),
               .left_entry  (new_entry),
               .left_gt     (1'b0),
               .right_entry (cells[g+1]),
               .gt          (gt[g]),
               .entry       (cells[g]),
               .rd_part     (parts[g])
            );
         end else begin : g_single
            sst_cell u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .pos         (pos[g]),
               .left_entry  (new_entry),
               .left_gt     (1'b0),
               .right_entry (cells[g]),
               .gt          (gt[g]),
               .entry       (cells[g]),
               .rd_part     (parts[g])
            );
         end
      end else if (g == MAX_ENTRIES - 1) begin : g_last
         sst_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .pos         (pos[g]),
            .left_entry  (cells[g-1]),
            .left_gt     (gt[g-1]),
            .right_entry (cells[g]),
            .gt          (gt[g]),
            .entry       (cells[g]),
            .rd_part     (parts[g])
         );
      end else begin : g_mid
         sst_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .pos         (pos[g]),
            .left_entry  (cells[g-1]),
            .left_gt     (gt[g-1]),
            .right_entry (cells[g+1]),
            .gt          (gt[g]),
            .entry       (cells[g]),
            .rd_part     (parts[g])
         );
      end
   end

   // Only the selected cell drives a nonzero part, so an OR collects it.
   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rd_bus = rd_bus | parts[i];
      end
   end

   // Sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STATUS_DONE;
            rd_in     = '0;
            state_in  = S_DONE;
            if (op_ff.mode == MODE_INSERT) begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else if (out_of_range) begin
               status_in = STATUS_RANGE;
            end else if (op_ff.mode == MODE_REMOVE) begin
               count_in = count_ff - 1'b1;
            end else if (op_ff.mode == MODE_REPLACE) begin
               count_in = count_ff - 1'b1;
               state_in = S_INSERT;
            end else begin
               rd_in = rd_bus;
            end
         end
         S_INSERT: begin
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.entry_count     = COUNT_OUT_W'(count_ff);
               rsp_data_in.rd_start_minute = rd_ff.start_minute;
               rsp_data_in.rd_from_hour    = rd_ff.from_hour;
               rsp_data_in.rd_from_day     = rd_ff.from_day;
               rsp_data_in.rd_stop_minute  = rd_ff.stop_minute;
               rsp_data_in.rd_stop_hour    = rd_ff.stop_hour;
               rsp_data_in.rd_stop_day     = rd_ff.stop_day;
               rsp_data_in.rd_preset       = rd_ff.preset;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // The count never runs past the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count exceeds table depth");

   // An accepted request always moves straight into execution.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not start");

   // An insert into a full table leaves the count unchanged.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff.mode == MODE_INSERT && full)
      |=> (count_ff == CNT_W'(MAX_ENTRIES)))
      else $error("full insert changed the count");

   // A failed operation never returns entry data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_DONE)
      |-> (rsp_data_ff.rd_start_minute == '0 && rsp_data_ff.rd_from_hour == '0 &&
           rsp_data_ff.rd_from_day == '0 && rsp_data_ff.rd_preset == '0))
      else $error("failed response carries entry data");

endmodule
